// ===== hw/rtl/aavr_pkg.sv =====
package aavr_pkg;

	localparam int SINCOS_STAGES = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int CS_W = 34;   // CORDIC x, y (Q30)
	localparam int Z_W = 36;    // angle during reduction and iteration (Q30)
	localparam int M_W = 36;    // matrix entry (Q28)

	localparam logic signed [Z_W-1:0] Q30_PI = 36'sd3373259426;
	localparam logic signed [Z_W-1:0] Q30_TWO_PI = 36'sd6746518852;
	localparam logic signed [Z_W-1:0] Q30_HALF_PI = 36'sd1686629713;
	localparam logic signed [CS_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
	} item_t;

	typedef struct packed {
		logic signed [M_W-1:0] m00;
		logic signed [M_W-1:0] m01;
		logic signed [M_W-1:0] m02;
		logic signed [M_W-1:0] m10;
		logic signed [M_W-1:0] m11;
		logic signed [M_W-1:0] m12;
		logic signed [M_W-1:0] m20;
		logic signed [M_W-1:0] m21;
		logic signed [M_W-1:0] m22;
	} mat_t;

	// atan(2^-i) in Q30, truncated
	function automatic logic [29:0] atan_q30(input int i);
		logic [29:0] r;
		unique case (i)
			0: r = 30'h3243F6A8;
			1: r = 30'h1DAC6705;
			2: r = 30'h0FADBAFC;
			3: r = 30'h07F56EA6;
			4: r = 30'h03FEAB76;
			5: r = 30'h01FFD55B;
			6: r = 30'h00FFFAAA;
			7: r = 30'h007FFF55;
			8: r = 30'h003FFFEA;
			9: r = 30'h001FFFFD;
			10: r = 30'h000FFFFF;
			11: r = 30'h0007FFFF;
			12: r = 30'h0003FFFF;
			13: r = 30'h0001FFFF;
			14: r = 30'h0000FFFF;
			15: r = 30'h00007FFF;
			16: r = 30'h00003FFF;
			17: r = 30'h00001FFF;
			18: r = 30'h00000FFF;
			19: r = 30'h000007FF;
			20: r = 30'h000003FF;
			21: r = 30'h000001FF;
			22: r = 30'h000000FF;
			23: r = 30'h0000007F;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/aavr_sincos.sv =====
module aavr_sincos (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                valid_in,
	input  aavr_pkg::item_t                     item_in,
	input  logic signed [15:0]                  angle_in,
	output logic                                valid_out,
	output aavr_pkg::item_t                     item_out,
	output logic                                flip_out,
	output logic signed [aavr_pkg::CS_W-1:0]    cos_out,
	output logic signed [aavr_pkg::CS_W-1:0]    sin_out
);
	import aavr_pkg::*;

	localparam int NST = (SINCOS_STAGES < ATAN_ENTRIES) ? SINCOS_STAGES : ATAN_ENTRIES;

	logic signed [Z_W-1:0] z_wide;
	logic signed [Z_W-1:0] z_s1;
	logic                  v_s1;
	item_t                 itm_s1;
	logic signed [Z_W-1:0] z_s2;
	logic                  v_s2;
	logic                  flip_s2;
	item_t                 itm_s2;

	logic                  vld_q  [0:NST];
	logic                  flp_q  [0:NST];
	item_t                 itm_q  [0:NST];
	logic signed [CS_W-1:0] x_q   [0:NST];
	logic signed [CS_W-1:0] y_q   [0:NST];
	logic signed [Z_W-1:0]  z_q   [0:NST];

	assign z_wide = {{2{angle_in[15]}}, angle_in, 18'b0};

	// reduce into [-pi, pi]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			itm_s1 <= item_in;
			if (z_wide > Q30_PI) begin
				z_s1 <= z_wide - Q30_TWO_PI;
			end else if (z_wide < -Q30_PI) begin
				z_s1 <= z_wide + Q30_TWO_PI;
			end else begin
				z_s1 <= z_wide;
			end
		end
	end

	// fold into [-pi/2, pi/2]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			itm_s2 <= itm_s1;
			if (z_s1 > Q30_HALF_PI) begin
				z_s2 <= z_s1 - Q30_PI;
				flip_s2 <= 1'b1;
			end else if (z_s1 < -Q30_HALF_PI) begin
				z_s2 <= z_s1 + Q30_PI;
				flip_s2 <= 1'b1;
			end else begin
				z_s2 <= z_s1;
				flip_s2 <= 1'b0;
			end
		end
	end

	assign vld_q[0] = v_s2;
	assign flp_q[0] = flip_s2;
	assign itm_q[0] = itm_s2;
	assign x_q[0] = CORDIC_GAIN_Q30;
	assign y_q[0] = '0;
	assign z_q[0] = z_s2;

	for (genvar i = 0; i < NST; i++) begin : g_stage
		logic [Z_W-1:0] at;
		assign at = {{(Z_W-30){1'b0}}, atan_q30(i)};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i+1] <= 1'b0;
			end else if (en) begin
				vld_q[i+1] <= vld_q[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				flp_q[i+1] <= flp_q[i];
				itm_q[i+1] <= itm_q[i];
				if (z_q[i] >= 0) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - $signed(at);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + $signed(at);
				end
			end
		end
	end

	assign valid_out = vld_q[NST];
	assign item_out = itm_q[NST];
	assign flip_out = flp_q[NST];
	assign cos_out = x_q[NST];
	assign sin_out = y_q[NST];

endmodule

// ===== hw/rtl/aavr_matrix.sv =====
module aavr_matrix (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             valid_in,
	input  aavr_pkg::item_t                  item_in,
	input  logic                             flip_in,
	input  logic signed [aavr_pkg::CS_W-1:0] cos_in,
	input  logic signed [aavr_pkg::CS_W-1:0] sin_in,
	output logic                             valid_out,
	output aavr_pkg::item_t                  item_out,
	output aavr_pkg::mat_t                   mat_out
);
	import aavr_pkg::*;

	// stage 1: sign fix, k, axis products
	logic               v_s1;
	item_t              itm_s1;
	logic signed [34:0] c_s1, s_s1;
	logic signed [35:0] k_s1;
	logic signed [31:0] pxx_s1, pyy_s1, pzz_s1, pxy_s1, pxz_s1, pyz_s1;
	// stage 2: wide products
	logic               v_s2;
	item_t              itm_s2;
	logic signed [67:0] kxx_s2, kyy_s2, kzz_s2, kxy_s2, kxz_s2, kyz_s2;
	logic signed [64:0] c60_s2;
	logic signed [50:0] sx_s2, sy_s2, sz_s2;
	// stage 3: entries
	logic               v_s3;
	item_t              itm_s3;
	mat_t               m_s3;

	logic signed [34:0] c_ext, s_ext;
	logic signed [69:0] c60w, sxw, syw, szw;
	logic signed [69:0] kxxw, kyyw, kzzw, kxyw, kxzw, kyzw;

	assign c_ext = {cos_in[CS_W-1], cos_in};
	assign s_ext = {sin_in[CS_W-1], sin_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			itm_s1 <= item_in;
			c_s1 <= flip_in ? -c_ext : c_ext;
			s_s1 <= flip_in ? -s_ext : s_ext;
			k_s1 <= 36'sd1073741824 - (flip_in ? -36'(c_ext) : 36'(c_ext));
			pxx_s1 <= item_in.ax * item_in.ax;
			pyy_s1 <= item_in.ay * item_in.ay;
			pzz_s1 <= item_in.az * item_in.az;
			pxy_s1 <= item_in.ax * item_in.ay;
			pxz_s1 <= item_in.ax * item_in.az;
			pyz_s1 <= item_in.ay * item_in.az;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			itm_s2 <= itm_s1;
			kxx_s2 <= k_s1 * pxx_s1;
			kyy_s2 <= k_s1 * pyy_s1;
			kzz_s2 <= k_s1 * pzz_s1;
			kxy_s2 <= k_s1 * pxy_s1;
			kxz_s2 <= k_s1 * pxz_s1;
			kyz_s2 <= k_s1 * pyz_s1;
			c60_s2 <= {c_s1, 30'b0};
			sx_s2 <= s_s1 * itm_s1.ax;
			sy_s2 <= s_s1 * itm_s1.ay;
			sz_s2 <= s_s1 * itm_s1.az;
		end
	end

	assign c60w = 70'(c60_s2);
	assign sxw = {{4{sx_s2[50]}}, sx_s2, 15'b0};
	assign syw = {{4{sy_s2[50]}}, sy_s2, 15'b0};
	assign szw = {{4{sz_s2[50]}}, sz_s2, 15'b0};
	assign kxxw = 70'(kxx_s2);
	assign kyyw = 70'(kyy_s2);
	assign kzzw = 70'(kzz_s2);
	assign kxyw = 70'(kxy_s2);
	assign kxzw = 70'(kxz_s2);
	assign kyzw = 70'(kyz_s2);

	// round half up from Q60 to Q28
	function automatic logic signed [M_W-1:0] to_q28(input logic signed [69:0] v);
		logic signed [69:0] r;
		r = (v + 70'sd2147483648) >>> 32;
		return r[M_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			itm_s3 <= itm_s2;
			m_s3.m00 <= to_q28(c60w + kxxw);
			m_s3.m11 <= to_q28(c60w + kyyw);
			m_s3.m22 <= to_q28(c60w + kzzw);
			m_s3.m01 <= to_q28(kxyw - szw);
			m_s3.m10 <= to_q28(kxyw + szw);
			m_s3.m02 <= to_q28(kxzw + syw);
			m_s3.m20 <= to_q28(kxzw - syw);
			m_s3.m12 <= to_q28(kyzw - sxw);
			m_s3.m21 <= to_q28(kyzw + sxw);
		end
	end

	assign valid_out = v_s3;
	assign item_out = itm_s3;
	assign mat_out = m_s3;

endmodule

// ===== hw/rtl/aavr_apply.sv =====
module aavr_apply (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  aavr_pkg::item_t    item_in,
	input  aavr_pkg::mat_t     mat_in,
	output logic               valid_out,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z
);
	import aavr_pkg::*;

	localparam int P_W = 32 + M_W;

	logic                  v_s1;
	logic signed [P_W-1:0] p00_s1, p01_s1, p02_s1;
	logic signed [P_W-1:0] p10_s1, p11_s1, p12_s1;
	logic signed [P_W-1:0] p20_s1, p21_s1, p22_s1;
	logic                  v_s2;
	logic signed [31:0]    x_s2, y_s2, z_s2;

	function automatic logic signed [31:0] sat_q16(input logic signed [P_W-1:0] a,
			input logic signed [P_W-1:0] b, input logic signed [P_W-1:0] c);
		logic signed [P_W+1:0] sum;
		logic signed [P_W+1:0] r;
		logic signed [31:0] o;
		sum = (P_W+2)'(a) + (P_W+2)'(b) + (P_W+2)'(c);
		r = (sum + (P_W+2)'(29'sd134217728)) >>> 28;
		if (r > (P_W+2)'(32'sh7FFFFFFF)) begin
			o = 32'sh7FFFFFFF;
		end else if (r < -(P_W+2)'(33'sh080000000)) begin
			o = 32'sh80000000;
		end else begin
			o = r[31:0];
		end
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= item_in.vx * mat_in.m00;
			p01_s1 <= item_in.vy * mat_in.m01;
			p02_s1 <= item_in.vz * mat_in.m02;
			p10_s1 <= item_in.vx * mat_in.m10;
			p11_s1 <= item_in.vy * mat_in.m11;
			p12_s1 <= item_in.vz * mat_in.m12;
			p20_s1 <= item_in.vx * mat_in.m20;
			p21_s1 <= item_in.vy * mat_in.m21;
			p22_s1 <= item_in.vz * mat_in.m22;
			x_s2 <= sat_q16(p00_s1, p01_s1, p02_s1);
			y_s2 <= sat_q16(p10_s1, p11_s1, p12_s1);
			z_s2 <= sat_q16(p20_s1, p21_s1, p22_s1);
		end
	end

	assign valid_out = v_s2;
	assign out_x = x_s2;
	assign out_y = y_s2;
	assign out_z = z_s2;

endmodule

// ===== hw/rtl/axis_angle_vector_rotation.sv =====
// Axis-angle vector rotation (Rodrigues formula).
// Input channel (in_valid/in_ready): vec_x/y/z signed Q16.16, angle_rad
// signed Q4.12 radians, axis_x/y/z signed Q1.15 (used as given, not
// normalized). Output channel (out_valid/out_ready): rot_x/y/z signed
// Q16.16, rounded and saturated.
// Each item passes in order through the angle reduction and fold registers,
// the CORDIC stages, the matrix stages, and the product and saturation
// registers of the vector product. Throughput is one item per cycle while
// the receiver does not stall; every stage is a register with a valid bit,
// and the whole pipe advances together. When the receiver stalls with a
// result waiting, the pipe freezes and in_ready drops; nothing is dropped
// or repeated. Empty slots behind a stalled result are not squeezed out;
// while the last stage is empty the pipe keeps moving.
// Reset clears all valid bits; out_valid is low after reset.
module axis_angle_vector_rotation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic signed [15:0] angle_rad,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] rot_x,
	output logic signed [31:0] rot_y,
	output logic signed [31:0] rot_z
);
	import aavr_pkg::*;

	logic                  en;
	item_t                 item_in;
	logic                  sc_valid;
	item_t                 sc_item;
	logic                  sc_flip;
	logic signed [CS_W-1:0] sc_cos, sc_sin;
	logic                  mx_valid;
	item_t                 mx_item;
	mat_t                  mx_mat;

	// advance when the output slot is empty or being taken
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	assign item_in.vx = vec_x;
	assign item_in.vy = vec_y;
	assign item_in.vz = vec_z;
	assign item_in.ax = axis_x;
	assign item_in.ay = axis_y;
	assign item_in.az = axis_z;

	aavr_sincos u_sincos (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (in_valid),
		.item_in  (item_in),
		.angle_in (angle_rad),
		.valid_out(sc_valid),
		.item_out (sc_item),
		.flip_out (sc_flip),
		.cos_out  (sc_cos),
		.sin_out  (sc_sin)
	);

	aavr_matrix u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (sc_valid),
		.item_in  (sc_item),
		.flip_in  (sc_flip),
		.cos_in   (sc_cos),
		.sin_in   (sc_sin),
		.valid_out(mx_valid),
		.item_out (mx_item),
		.mat_out  (mx_mat)
	);

	aavr_apply u_apply (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (mx_valid),
		.item_in  (mx_item),
		.mat_in   (mx_mat),
		.valid_out(out_valid),
		.out_x    (rot_x),
		.out_y    (rot_y),
		.out_z    (rot_z)
	);

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(sc_valid) && $stable(mx_valid) && $stable(sc_cos))
		else $error("pipe moved during stall");

	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		sc_valid |-> (sc_cos <= 34'sd1074790400) && (sc_cos >= -34'sd1074790400)
			&& (sc_sin <= 34'sd1074790400) && (sc_sin >= -34'sd1074790400))
		else $error("CORDIC output out of range");

	a_mx_move: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> out_valid == $past(u_apply.v_s1))
		else $error("result valid lost between stages");

endmodule
